// ===== src/can_fragment_reassembly_assert.svh =====
// Assertion macros shared by the reassembly block.
`ifndef CAN_FRAGMENT_REASSEMBLY_ASSERT_SVH
`define CAN_FRAGMENT_REASSEMBLY_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CFR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfr assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfr assertion failed");

`endif

// ===== src/cfr_pkg.sv =====
// Types and constants of the CAN fragment reassembly block.
package cfr_pkg;

    localparam logic [3:0] TYPE_BEGIN = 4'd0;
    localparam logic [3:0] TYPE_MORE  = 4'd1;
    localparam logic [28:0] KEY_MASK  = 29'h1FFFE1FF;
    localparam logic [16:0] PLAIN_EXTRA = 17'd3;
    localparam logic [3:0] HDR_BYTES  = 4'd6;
    localparam logic [3:0] PLAIN_MIN  = 4'd2;
    localparam logic [3:0] MAX_DLC    = 4'd8;

    localparam logic [2:0] CFG_IDLE_TIMEOUT = 3'd0;
    localparam logic [2:0] CFG_MAX_BYTES    = 3'd1;
    localparam logic [2:0] CFG_RESET_CODE   = 3'd2;
    localparam logic [2:0] CFG_TSYNC_CODE   = 3'd3;
    localparam logic [2:0] CFG_SINGLE_CODE  = 3'd4;

    localparam logic [2:0] STAT_PARTIAL  = 3'd0;
    localparam logic [2:0] STAT_COMPLETE = 3'd1;
    localparam logic [2:0] STAT_NO_CTX   = 3'd2;
    localparam logic [2:0] STAT_FULL     = 3'd3;
    localparam logic [2:0] STAT_OVERFLOW = 3'd4;
    localparam logic [2:0] STAT_UNKNOWN  = 3'd5;
    localparam logic [2:0] STAT_BAD_HDR  = 3'd6;
    localparam logic [2:0] STAT_SWEPT    = 3'd7;

    typedef struct packed {
        logic load_item;
        logic search;
        logic commit;
    } cfr_cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot_index;
        logic [15:0] write_offset;
        logic [3:0]  write_count;
        logic [63:0] write_data;
        logic [15:0] packet_length;
        logic [31:0] packet_header_id;
        logic        library_format;
        logic        replaced_incomplete;
        logic [7:0]  freed_slots;
    } cfr_result_t;

    function automatic logic [63:0] keep_bytes(input logic [63:0] d, input logic [3:0] n);
        logic [63:0] m;
        for (int k = 0; k < 8; k++)
        begin
            m[63 - 8 * k -: 8] = (n > 4'(k)) ? 8'hFF : 8'h00;
        end
        return d & m;
    endfunction

endpackage

// ===== src/cfr_ctrl.sv =====
// Sequencing controller: accept, slot search, commit and result hold.
module cfr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output cfr_pkg::cfr_cmd_t cmd
);
    import cfr_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_EXEC   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/cfr_datapath.sv =====
// Slot table, configuration registers and result computation.
module cfr_datapath
#(
    parameter int SLOTS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfr_pkg::cfr_cmd_t    cmd,
    input  logic                 item_opcode,
    input  logic [28:0]          item_can_id,
    input  logic [3:0]           item_frame_length,
    input  logic [63:0]          item_frame_data,
    input  logic [31:0]          item_now_ms,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output cfr_pkg::cfr_result_t result
);
    import cfr_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic        op_reg;
    logic [28:0] id_reg;
    logic [3:0]  dlc_reg;
    logic [63:0] data_reg;
    logic [31:0] now_reg;

    logic [31:0] tmo_reg;
    logic [15:0] maxlen_reg;
    logic [3:0]  rst_code_reg;
    logic [3:0]  ts_code_reg;
    logic [3:0]  sgl_code_reg;

    logic              use_reg  [SLOTS];
    logic [28:0]       key_reg  [SLOTS];
    logic [15:0]       rcv_reg  [SLOTS];
    logic [31:0]       last_reg [SLOTS];
    logic [15:0]       len_reg  [SLOTS];
    logic [31:0]       hid_reg  [SLOTS];

    logic              found_reg;
    logic [SLOT_W-1:0] mslot_reg;
    logic              fany_reg;
    logic [SLOT_W-1:0] fslot_reg;
    logic [SLOTS-1:0]  exp_reg;

    logic              found_next;
    logic [SLOT_W-1:0] mslot_next;
    logic              fany_next;
    logic [SLOT_W-1:0] fslot_next;
    logic [SLOTS-1:0]  exp_next;

    cfr_result_t       result_reg;
    cfr_result_t       result_next;

    logic [3:0]        typ;
    logic              fmt;
    logic              is_single;
    logic              is_begin;
    logic              is_more;
    logic [SLOT_W-1:0] slot;
    logic              have;
    logic [31:0]       b_hid;
    logic [16:0]       b_len;
    logic              b_short;
    logic [15:0]       cur_len;
    logic [31:0]       cur_hid;
    logic [15:0]       rx;
    logic [3:0]        nb;
    logic [63:0]       shifted;
    logic [16:0]       sum;
    logic [SLOTS+7:0]  exp_ext;
    logic [SLOT_W+2:0] slot_ext;
    logic              do_sel;
    logic              do_alloc;
    logic              do_free;
    logic              do_begin;
    logic              do_rcv;

    assign result = result_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= item_opcode;
            id_reg   <= item_can_id;
            dlc_reg  <= (item_frame_length > MAX_DLC) ? MAX_DLC : item_frame_length;
            data_reg <= item_frame_data;
            now_reg  <= item_now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmo_reg      <= 32'd5000;
            maxlen_reg   <= 16'd256;
            rst_code_reg <= 4'd2;
            ts_code_reg  <= 4'd3;
            sgl_code_reg <= 4'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDLE_TIMEOUT: tmo_reg      <= cfg_data;
                CFG_MAX_BYTES:    maxlen_reg   <= cfg_data[15:0];
                CFG_RESET_CODE:   rst_code_reg <= cfg_data[3:0];
                CFG_TSYNC_CODE:   ts_code_reg  <= cfg_data[3:0];
                CFG_SINGLE_CODE:  sgl_code_reg <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    // Slot search: key match, lowest free slot and idle expiry, one lane per slot.
    always_comb
    begin
        found_next = 1'b0;
        mslot_next = '0;
        fany_next  = 1'b0;
        fslot_next = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            exp_next[s] = use_reg[s] && ((now_reg - last_reg[s]) > tmo_reg);
            if (use_reg[s] && (((key_reg[s] ^ id_reg) & KEY_MASK) == 29'd0))
            begin
                found_next = 1'b1;
                mslot_next = SLOT_W'(s);
            end
            if (!use_reg[s])
            begin
                fany_next  = 1'b1;
                fslot_next = SLOT_W'(s);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.search)
        begin
            found_reg <= found_next;
            mslot_reg <= mslot_next;
            fany_reg  <= fany_next;
            fslot_reg <= fslot_next;
            exp_reg   <= exp_next;
        end
    end

    always_comb
    begin
        typ       = id_reg[12:9];
        fmt       = id_reg[8];
        is_single = (typ == rst_code_reg) || (typ == ts_code_reg) || (typ == sgl_code_reg);
        is_begin  = !is_single && (typ == TYPE_BEGIN);
        is_more   = !is_single && !is_begin && (typ == TYPE_MORE);
        slot      = found_reg ? mslot_reg : fslot_reg;
        have      = found_reg || (fany_reg && (is_single || is_begin));
        b_hid     = fmt ? data_reg[63:32] : {3'b000, id_reg};
        b_len     = fmt ? {1'b0, data_reg[31:16]} : ({1'b0, data_reg[63:48]} + PLAIN_EXTRA);
        b_short   = fmt ? (dlc_reg < HDR_BYTES) : (dlc_reg < PLAIN_MIN);
        cur_len   = is_begin ? b_len[15:0] : len_reg[slot];
        cur_hid   = is_begin ? b_hid : hid_reg[slot];
        rx        = is_begin ? 16'd0 : rcv_reg[slot];
        nb        = (is_begin && fmt) ? (dlc_reg - HDR_BYTES) : dlc_reg;
        shifted   = (is_begin && fmt) ? {data_reg[15:0], 48'd0} : data_reg;
        sum       = {1'b0, rx} + {13'd0, nb};
        exp_ext   = {8'd0, exp_reg};
        slot_ext  = {3'b000, slot};

        result_next = '0;
        result_next.status           = STAT_PARTIAL;
        result_next.packet_header_id = {3'b000, id_reg};
        result_next.library_format   = fmt;
        do_sel   = 1'b0;
        do_alloc = 1'b0;
        do_free  = 1'b0;
        do_begin = 1'b0;
        do_rcv   = 1'b0;

        if (op_reg)
        begin
            result_next = '0;
            result_next.status      = STAT_SWEPT;
            result_next.freed_slots = exp_ext[7:0];
        end
        else if (!found_reg && !(is_single || is_begin))
        begin
            result_next.status = STAT_NO_CTX;
        end
        else if (!have)
        begin
            result_next.status = STAT_FULL;
        end
        else
        begin
            do_sel   = 1'b1;
            do_alloc = !found_reg;
            result_next.slot_index = slot_ext[2:0];
            if (is_single)
            begin
                result_next.status        = STAT_COMPLETE;
                result_next.write_count   = dlc_reg;
                result_next.write_data    = keep_bytes(data_reg, dlc_reg);
                result_next.packet_length = {12'd0, dlc_reg};
                do_free = 1'b1;
            end
            else if (is_begin && b_short)
            begin
                result_next.replaced_incomplete = found_reg;
                result_next.status              = STAT_BAD_HDR;
                do_free = 1'b1;
            end
            else if (is_begin && (b_len > {1'b0, maxlen_reg}))
            begin
                result_next.replaced_incomplete = found_reg;
                result_next.packet_header_id    = b_hid;
                result_next.status              = STAT_BAD_HDR;
                do_free = 1'b1;
            end
            else if (!is_begin && !is_more)
            begin
                result_next.status = STAT_UNKNOWN;
                do_free = 1'b1;
            end
            else
            begin
                result_next.replaced_incomplete = is_begin && found_reg;
                result_next.packet_length       = cur_len;
                result_next.packet_header_id    = cur_hid;
                result_next.write_offset        = rx;
                do_begin = is_begin;
                if (sum > {1'b0, cur_len})
                begin
                    result_next.status = STAT_OVERFLOW;
                    do_free = 1'b1;
                end
                else
                begin
                    result_next.write_count = nb;
                    result_next.write_data  = keep_bytes(shifted, nb);
                    do_rcv = 1'b1;
                    if (sum >= {1'b0, cur_len})
                    begin
                        result_next.status = STAT_COMPLETE;
                        do_free = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                use_reg[s]  <= 1'b0;
                key_reg[s]  <= '0;
                rcv_reg[s]  <= '0;
                last_reg[s] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                if (op_reg)
                begin
                    if (exp_reg[s])
                    begin
                        use_reg[s]  <= 1'b0;
                        key_reg[s]  <= '0;
                        rcv_reg[s]  <= '0;
                        last_reg[s] <= '0;
                    end
                end
                else if (do_sel && (slot == SLOT_W'(s)))
                begin
                    if (do_free)
                    begin
                        use_reg[s]  <= 1'b0;
                        key_reg[s]  <= '0;
                        rcv_reg[s]  <= '0;
                        last_reg[s] <= '0;
                    end
                    else
                    begin
                        use_reg[s]  <= 1'b1;
                        last_reg[s] <= now_reg;
                        if (do_alloc)
                        begin
                            key_reg[s] <= id_reg;
                        end
                        if (do_rcv)
                        begin
                            rcv_reg[s] <= sum[15:0];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && !op_reg && do_sel && do_begin)
        begin
            len_reg[slot] <= cur_len;
            hid_reg[slot] <= b_hid;
        end
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== src/can_fragment_reassembly.sv =====
// Sequence: a request is accepted, then the slot search runs, then the commit registers the result;
// a new request is accepted only after the commit of the previous one;
// a stalled result holds the commit until the output register frees.
// Reset: all slots free, registers at their defaults, no clearing pass.
// Top level of the CAN fragment reassembly block.
module can_fragment_reassembly
#(
    parameter int SLOTS = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // can_id[28:0], frame_length[32:29], frame_data[96:33], now_ms[128:97]
    input  logic [135:0] s_axis_tdata,
    // opcode[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // slot_index[2:0], write_offset[18:3], write_count[22:19], write_data[86:23],
    // packet_length[102:87], packet_header_id[134:103], library_format[135],
    // replaced_incomplete[136], freed_slots[144:137]
    output logic [151:0] m_axis_tdata,
    // status[2:0]
    output logic [2:0]   m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import cfr_pkg::*;

    cfr_cmd_t    cmd;
    cfr_result_t res;

    assign cfg_ready = 1'b1;

    cfr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    cfr_datapath #(.SLOTS(SLOTS)) u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .item_opcode       (s_axis_tuser),
        .item_can_id       (s_axis_tdata[28:0]),
        .item_frame_length (s_axis_tdata[32:29]),
        .item_frame_data   (s_axis_tdata[96:33]),
        .item_now_ms       (s_axis_tdata[128:97]),
        .cfg_we            (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .result            (res)
    );

    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {7'd0, res.freed_slots, res.replaced_incomplete,
                           res.library_format, res.packet_header_id, res.packet_length,
                           res.write_data, res.write_count, res.write_offset,
                           res.slot_index};

`include "can_fragment_reassembly_assert.svh"

    `CFR_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `CFR_ASSERT_NEXT(a_search_follows_load, cmd.load_item, cmd.search)
    `CFR_ASSERT_NEXT(a_commit_gives_result, cmd.commit, m_axis_tvalid)
    `CFR_ASSERT_NOW(a_commit_output_free, cmd.commit, !m_axis_tvalid || m_axis_tready)

endmodule

// ===== verif/can_fragment_reassembly_tb.sv =====
// Testbench for the CAN fragment reassembly block: directed table and random frame sequences.
`timescale 1ns / 100ps

module can_fragment_reassembly_tb;
    import cfr_pkg::*;

    localparam int NSLOTS = 8;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [151:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    can_fragment_reassembly #(.SLOTS(NSLOTS)) dut (.*);

    typedef struct {
        logic        op;
        logic [28:0] id;
        logic [3:0]  dlc;
        logic [63:0] data;
        logic [31:0] stamp;
        logic        chk;
        logic [2:0]  st;
    } request_row_t;

    // Mirror of the context table and registers.
    logic [31:0] timeout_ms;
    logic [15:0] max_bytes;
    logic [3:0]  code_reset;
    logic [3:0]  code_tsync;
    logic [3:0]  code_single;
    logic        ctx_busy [NSLOTS];
    logic [28:0] ctx_key [NSLOTS];
    logic [15:0] ctx_rcvd [NSLOTS];
    logic [15:0] ctx_len [NSLOTS];
    logic [31:0] ctx_hid [NSLOTS];
    logic [31:0] ctx_stamp [NSLOTS];

    cfr_result_t pending_results[$];
    int mismatches = 0;
    int idle_cycles = 0;
    int snd_idle = 0;
    int rcv_idle = 0;
    int hold_count = 0;
    logic [28:0] key_pool [4];
    logic [31:0] clock_ms = 0;

    function automatic logic [28:0] make_id(int src, int dst, int typ, int fmt, int ses);
        return {8'(src), 8'(dst), 4'(typ), 1'(fmt), 8'(ses)};
    endfunction

    function automatic logic [63:0] first_bytes(logic [63:0] d, int n);
        if (n <= 0)
            return 64'h0;
        return d & (~64'h0 << (64 - 8 * n));
    endfunction

    function automatic void release_ctx(int s);
        ctx_busy[s] = 1'b0;
        ctx_key[s] = '0;
        ctx_rcvd[s] = '0;
        ctx_stamp[s] = '0;
    endfunction

    function automatic cfr_result_t reassemble_step(logic op, logic [28:0] id, logic [3:0] dlc_in,
                                                    logic [63:0] d, logic [31:0] stamp);
        cfr_result_t r;
        logic [3:0] typ;
        int dlc, s, slot, skip, len, rx, n;
        logic found, have, single;
        logic [31:0] hid;
        r = '0;
        typ = id[12:9];
        slot = 0;
        found = 1'b0;
        have = 1'b0;
        skip = 0;
        if (op)
        begin
            for (s = 0; s < NSLOTS; s++)
            begin
                if (ctx_busy[s] && (stamp - ctx_stamp[s]) > timeout_ms)
                begin
                    release_ctx(s);
                    r.freed_slots[s] = 1'b1;
                end
            end
            r.status = STAT_SWEPT;
            return r;
        end
        dlc = (dlc_in > 8) ? 8 : int'(dlc_in);
        r.packet_header_id = 32'(id);
        r.library_format = id[8];
        for (s = 0; s < NSLOTS && !found; s++)
        begin
            if (ctx_busy[s] && ((ctx_key[s] ^ id) & KEY_MASK) == '0)
            begin
                slot = s;
                found = 1'b1;
                ctx_stamp[s] = stamp;
            end
        end
        have = found;
        single = (typ == code_reset || typ == code_tsync || typ == code_single);
        if (!have)
        begin
            if (!single && typ != TYPE_BEGIN)
            begin
                r.status = STAT_NO_CTX;
                return r;
            end
            for (s = 0; s < NSLOTS && !have; s++)
            begin
                if (!ctx_busy[s])
                begin
                    slot = s;
                    have = 1'b1;
                    ctx_busy[s] = 1'b1;
                    ctx_key[s] = id;
                    ctx_stamp[s] = stamp;
                end
            end
            if (!have)
            begin
                r.status = STAT_FULL;
                return r;
            end
        end
        r.slot_index = 3'(slot);
        if (single)
        begin
            r.status = STAT_COMPLETE;
            r.write_count = 4'(dlc);
            r.write_data = first_bytes(d, dlc);
            r.packet_length = 16'(dlc);
            ctx_len[slot] = 16'(dlc);
            ctx_hid[slot] = 32'(id);
            release_ctx(slot);
            return r;
        end
        if (typ == TYPE_BEGIN)
        begin
            r.replaced_incomplete = found;
            if (id[8])
            begin
                if (dlc < 6)
                begin
                    r.status = STAT_BAD_HDR;
                    release_ctx(slot);
                    return r;
                end
                hid = d[63:32];
                len = int'(d[31:16]);
                skip = 6;
            end
            else
            begin
                if (dlc < 2)
                begin
                    r.status = STAT_BAD_HDR;
                    release_ctx(slot);
                    return r;
                end
                hid = 32'(id);
                len = int'(d[63:48]) + 3;
            end
            r.packet_header_id = hid;
            if (len > int'(max_bytes))
            begin
                r.status = STAT_BAD_HDR;
                release_ctx(slot);
                return r;
            end
            ctx_len[slot] = 16'(len);
            ctx_hid[slot] = hid;
            ctx_rcvd[slot] = '0;
        end
        else if (typ != TYPE_MORE)
        begin
            r.status = STAT_UNKNOWN;
            release_ctx(slot);
            return r;
        end
        len = int'(ctx_len[slot]);
        rx = int'(ctx_rcvd[slot]);
        n = dlc - skip;
        r.packet_length = 16'(len);
        r.packet_header_id = ctx_hid[slot];
        r.library_format = ctx_key[slot][8];
        r.write_offset = 16'(rx);
        if (rx + n > len)
        begin
            r.status = STAT_OVERFLOW;
            release_ctx(slot);
            return r;
        end
        r.write_count = 4'(n);
        r.write_data = first_bytes(d << (8 * skip), n);
        rx += n;
        ctx_rcvd[slot] = 16'(rx);
        if (rx >= len)
        begin
            r.status = STAT_COMPLETE;
            release_ctx(slot);
        end
        else
        begin
            r.status = STAT_PARTIAL;
        end
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic send_request(request_row_t q);
        cfr_result_t r;
        while ($urandom_range(99) < snd_idle)
            @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = q.op;
        s_axis_tdata = {7'b0, q.stamp, q.data, q.dlc, q.id};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = reassemble_step(q.op, q.id, q.dlc, q.data, q.stamp);
        if (q.chk && r.status !== q.st)
        begin
            $error("status: table %0d, model %0d", q.st, r.status);
            mismatches++;
        end
        pending_results.push_back(r);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] val);
        wait (pending_results.size() == 0);
        repeat (8) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_IDLE_TIMEOUT: timeout_ms = val;
            CFG_MAX_BYTES:    max_bytes = val[15:0];
            CFG_RESET_CODE:   code_reset = val[3:0];
            CFG_TSYNC_CODE:   code_tsync = val[3:0];
            CFG_SINGLE_CODE:  code_single = val[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a)
        begin
            $error("%s: expected %0h, actual %0h", name, e, a);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        cfr_result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatches++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("status", e.status, m_axis_tuser);
                check_field("slot_index", e.slot_index, m_axis_tdata[2:0]);
                check_field("write_offset", e.write_offset, m_axis_tdata[18:3]);
                check_field("write_count", e.write_count, m_axis_tdata[22:19]);
                check_field("write_data", e.write_data, m_axis_tdata[86:23]);
                check_field("packet_length", e.packet_length, m_axis_tdata[102:87]);
                check_field("packet_header_id", e.packet_header_id, m_axis_tdata[134:103]);
                check_field("library_format", e.library_format, m_axis_tdata[135]);
                check_field("replaced_incomplete", e.replaced_incomplete, m_axis_tdata[136]);
                check_field("freed_slots", e.freed_slots, m_axis_tdata[144:137]);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("can_fragment_reassembly_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_count > 0)
            begin
                m_axis_tready = 1'b0;
                hold_count--;
            end
            else
            begin
                m_axis_tready = ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    task automatic random_request(int k);
        request_row_t q;
        int pick, cap, len;
        q.chk = 1'b0;
        q.st = STAT_PARTIAL;
        q.op = 1'b0;
        q.data = {$urandom, $urandom};
        q.dlc = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd8;
        if ($urandom_range(15) == 0)
            clock_ms = $urandom;
        else
            clock_ms += $urandom_range(1500);
        q.stamp = clock_ms;
        pick = $urandom_range(99);
        q.id = key_pool[$urandom_range(3)];
        if (pick < 38)
        begin
            q.id[12:9] = TYPE_BEGIN;
            cap = (max_bytes < 60) ? int'(max_bytes) + 4 : 60;
            len = ($urandom_range(15) == 0) ? $urandom_range(65535) : $urandom_range(cap);
            if (q.id[8])
                q.data[31:16] = 16'(len);
            else
                q.data[63:48] = 16'((len >= 3) ? len - 3 : len);
        end
        else if (pick < 75)
        begin
            q.id[12:9] = TYPE_MORE;
        end
        else if (pick < 85)
        begin
            case ($urandom_range(2))
                0: q.id[12:9] = code_reset;
                1: q.id[12:9] = code_tsync;
                default: q.id[12:9] = code_single;
            endcase
        end
        else if (pick < 91)
        begin
            q.op = 1'b1;
            q.id = 29'($urandom);
        end
        else
        begin
            q.id = 29'($urandom);
        end
        if (k == 100)
            hold_count = HOLD_CYCLES;
        send_request(q);
    endtask

    request_row_t directed [$];
    logic [31:0] phase_cfg [4][5] = '{
        '{32'd5000, 32'd256, 32'd2, 32'd3, 32'd4},
        '{32'd0, 32'd8, 32'd15, 32'd15, 32'd15},
        '{32'hFFFFFFFF, 32'd65535, 32'd0, 32'd1, 32'd7},
        '{32'd12000, 32'd200, 32'd5, 32'd6, 32'd2}
    };

    initial
    begin
        int k;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IDLE_TIMEOUT;
        cfg_data = '0;
        timeout_ms = 32'd5000;
        max_bytes = 16'd256;
        code_reset = 4'd2;
        code_tsync = 4'd3;
        code_single = 4'd4;
        for (int s = 0; s < NSLOTS; s++)
        begin
            release_ctx(s);
            ctx_len[s] = '0;
            ctx_hid[s] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed.push_back('{0, make_id(1, 2, 1, 0, 9), 8, 64'h1122334455667788, 0, 1, STAT_NO_CTX});
        directed.push_back('{0, make_id(1, 2, 7, 1, 9), 8, '1, 0, 1, STAT_NO_CTX});
        directed.push_back('{0, make_id(255, 255, 4, 1, 255), 8, '1, '1, 1, STAT_COMPLETE});
        directed.push_back('{0, make_id(0, 0, 2, 0, 0), 0, '1, 0, 1, STAT_COMPLETE});
        directed.push_back('{0, make_id(3, 4, 3, 0, 1), 15, 64'hA5A5, 0, 1, STAT_COMPLETE});
        directed.push_back('{0, make_id(3, 4, 0, 0, 2), 1, '0, 0, 1, STAT_BAD_HDR});
        directed.push_back('{0, make_id(3, 4, 0, 1, 2), 5, '0, 0, 1, STAT_BAD_HDR});
        directed.push_back('{0, make_id(3, 4, 0, 0, 2), 8, '1, 0, 1, STAT_BAD_HDR});
        directed.push_back('{0, make_id(5, 6, 0, 0, 3), 8, 64'h0005_AABBCCDDEEFF, 10, 1, STAT_COMPLETE});
        directed.push_back('{0, make_id(5, 6, 0, 0, 4), 8, 64'h000D_0102030405_06, 11, 0, 0});
        directed.push_back('{0, make_id(5, 6, 1, 0, 4), 8, 64'h0807060504030201, 12, 0, 0});
        directed.push_back('{0, make_id(7, 8, 0, 1, 5), 8, 64'hDEADBEEF_000A_1234, 13, 0, 0});
        directed.push_back('{0, make_id(7, 8, 1, 1, 5), 8, 64'h0123456789ABCDEF, 14, 0, 0});
        directed.push_back('{0, make_id(9, 9, 0, 0, 6), 8, 64'h0007_000000000000, 15, 0, 0});
        directed.push_back('{0, make_id(9, 9, 0, 0, 6), 8, 64'h0007_111111111111, 16, 0, 0});
        directed.push_back('{0, make_id(9, 9, 1, 0, 6), 8, '1, 17, 1, STAT_OVERFLOW});
        directed.push_back('{0, make_id(9, 9, 0, 0, 7), 4, 64'h0030_0000_0000_0000, 18, 0, 0});
        directed.push_back('{0, make_id(9, 9, 9, 0, 7), 4, '1, 19, 1, STAT_UNKNOWN});
        for (int s = 0; s < NSLOTS; s++)
            directed.push_back('{0, make_id(20, 21, 0, 0, 40 + s), 2, 64'h0010 << 48, 20, 0, 0});
        directed.push_back('{0, make_id(20, 21, 0, 0, 99), 2, 64'h0010 << 48, 20, 1, STAT_FULL});
        directed.push_back('{1, '0, 0, '0, '1, 1, STAT_SWEPT});
        foreach (directed[i])
            send_request(directed[i]);

        k = 0;
        for (int p = 0; p < 4; p++)
        begin
            for (int r = 0; r < 5; r++)
                write_register(3'(r), phase_cfg[p][r]);
            for (int j = 0; j < 4; j++)
                key_pool[j] = make_id($urandom_range(3), $urandom_range(255), 0,
                                      $urandom_range(1), $urandom_range(255));
            for (int i = 0; i < 385; i++)
            begin
                if (k < 510)
                begin
                    snd_idle = 32;
                    rcv_idle = 55;
                end
                else if (k < 1020)
                begin
                    snd_idle = 55;
                    rcv_idle = 32;
                end
                else
                begin
                    snd_idle = 0;
                    rcv_idle = 0;
                end
                random_request(k);
                k++;
            end
        end

        wait (pending_results.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("can_fragment_reassembly_tb: done, clean");
        else
            $display("can_fragment_reassembly_tb: done, errors");
        $finish;
    end

endmodule
